@@ hdl/sc2a_pkg.sv @@
package sc2a_pkg;

  // Key codes below this count are printable
  localparam int unsigned KeyCount = 58;

  localparam logic [7:0] PrefixByte = 8'hE0;
  localparam logic [7:0] AltOffset  = 8'h80;

  localparam logic [6:0] KeyLshift = 7'h2A;
  localparam logic [6:0] KeyRshift = 7'h36;
  localparam logic [6:0] KeyCtrl   = 7'h1D;
  localparam logic [6:0] KeyAlt    = 7'h38;
  localparam logic [6:0] KeyCaps   = 7'h3A;
  localparam logic [6:0] KeyLeft   = 7'h4B;
  localparam logic [6:0] KeyRight  = 7'h4D;

  localparam logic [7:0] CodeLeft  = 8'h02;
  localparam logic [7:0] CodeRight = 8'h06;

  // Decode result handed from the decoder to the output register
  typedef struct packed {
    logic       emit;
    logic [7:0] char_code;
  } dec_res_t;

  // US layout, no modifiers
  function automatic logic [7:0] us_rom(input logic [6:0] code);
    logic [7:0] val;
    case (code)
      7'd1:  val = 8'h1B;
      7'd2:  val = 8'h31;
      7'd3:  val = 8'h32;
      7'd4:  val = 8'h33;
      7'd5:  val = 8'h34;
      7'd6:  val = 8'h35;
      7'd7:  val = 8'h36;
      7'd8:  val = 8'h37;
      7'd9:  val = 8'h38;
      7'd10: val = 8'h39;
      7'd11: val = 8'h30;
      7'd12: val = 8'h2D;
      7'd13: val = 8'h3D;
      7'd14: val = 8'h08;
      7'd15: val = 8'h09;
      7'd16: val = 8'h71;
      7'd17: val = 8'h77;
      7'd18: val = 8'h65;
      7'd19: val = 8'h72;
      7'd20: val = 8'h74;
      7'd21: val = 8'h79;
      7'd22: val = 8'h75;
      7'd23: val = 8'h69;
      7'd24: val = 8'h6F;
      7'd25: val = 8'h70;
      7'd26: val = 8'h5B;
      7'd27: val = 8'h5D;
      7'd28: val = 8'h0A;
      7'd30: val = 8'h61;
      7'd31: val = 8'h73;
      7'd32: val = 8'h64;
      7'd33: val = 8'h66;
      7'd34: val = 8'h67;
      7'd35: val = 8'h68;
      7'd36: val = 8'h6A;
      7'd37: val = 8'h6B;
      7'd38: val = 8'h6C;
      7'd39: val = 8'h3B;
      7'd40: val = 8'h27;
      7'd41: val = 8'h60;
      7'd43: val = 8'h5C;
      7'd44: val = 8'h7A;
      7'd45: val = 8'h78;
      7'd46: val = 8'h63;
      7'd47: val = 8'h76;
      7'd48: val = 8'h62;
      7'd49: val = 8'h6E;
      7'd50: val = 8'h6D;
      7'd51: val = 8'h2C;
      7'd52: val = 8'h2E;
      7'd53: val = 8'h2F;
      7'd55: val = 8'h2A;
      7'd57: val = 8'h20;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // US layout with shift
  function automatic logic [7:0] shift_rom(input logic [6:0] code);
    logic [7:0] val;
    case (code)
      7'd1:  val = 8'h1B;
      7'd2:  val = 8'h21;
      7'd3:  val = 8'h40;
      7'd4:  val = 8'h23;
      7'd5:  val = 8'h24;
      7'd6:  val = 8'h25;
      7'd7:  val = 8'h5E;
      7'd8:  val = 8'h26;
      7'd9:  val = 8'h2A;
      7'd10: val = 8'h28;
      7'd11: val = 8'h29;
      7'd12: val = 8'h5F;
      7'd13: val = 8'h2B;
      7'd14: val = 8'h08;
      7'd15: val = 8'h09;
      7'd16: val = 8'h51;
      7'd17: val = 8'h57;
      7'd18: val = 8'h45;
      7'd19: val = 8'h52;
      7'd20: val = 8'h54;
      7'd21: val = 8'h59;
      7'd22: val = 8'h55;
      7'd23: val = 8'h49;
      7'd24: val = 8'h4F;
      7'd25: val = 8'h50;
      7'd26: val = 8'h7B;
      7'd27: val = 8'h7D;
      7'd28: val = 8'h0A;
      7'd30: val = 8'h41;
      7'd31: val = 8'h53;
      7'd32: val = 8'h44;
      7'd33: val = 8'h46;
      7'd34: val = 8'h47;
      7'd35: val = 8'h48;
      7'd36: val = 8'h4A;
      7'd37: val = 8'h4B;
      7'd38: val = 8'h4C;
      7'd39: val = 8'h3A;
      7'd40: val = 8'h22;
      7'd41: val = 8'h7E;
      7'd43: val = 8'h7C;
      7'd44: val = 8'h5A;
      7'd45: val = 8'h58;
      7'd46: val = 8'h43;
      7'd47: val = 8'h56;
      7'd48: val = 8'h42;
      7'd49: val = 8'h4E;
      7'd50: val = 8'h4D;
      7'd51: val = 8'h3C;
      7'd52: val = 8'h3E;
      7'd53: val = 8'h3F;
      7'd55: val = 8'h2A;
      7'd57: val = 8'h20;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Control characters; slash and unused keys read zero
  function automatic logic [7:0] ctrl_rom(input logic [6:0] code);
    logic [7:0] val;
    case (code)
      7'd1:  val = 8'h1B;
      7'd2:  val = 8'h31;
      7'd3:  val = 8'h32;
      7'd4:  val = 8'h33;
      7'd5:  val = 8'h34;
      7'd6:  val = 8'h35;
      7'd7:  val = 8'h36;
      7'd8:  val = 8'h37;
      7'd9:  val = 8'h38;
      7'd10: val = 8'h39;
      7'd11: val = 8'h30;
      7'd12: val = 8'h1F;
      7'd13: val = 8'h3D;
      7'd14: val = 8'h08;
      7'd15: val = 8'h09;
      7'd16: val = 8'h11;
      7'd17: val = 8'h17;
      7'd18: val = 8'h05;
      7'd19: val = 8'h12;
      7'd20: val = 8'h14;
      7'd21: val = 8'h19;
      7'd22: val = 8'h15;
      7'd23: val = 8'h09;
      7'd24: val = 8'h0F;
      7'd25: val = 8'h10;
      7'd26: val = 8'h1B;
      7'd27: val = 8'h1D;
      7'd28: val = 8'h0A;
      7'd30: val = 8'h01;
      7'd31: val = 8'h13;
      7'd32: val = 8'h04;
      7'd33: val = 8'h06;
      7'd34: val = 8'h07;
      7'd35: val = 8'h08;
      7'd36: val = 8'h0A;
      7'd37: val = 8'h0B;
      7'd38: val = 8'h0C;
      7'd39: val = 8'h3B;
      7'd40: val = 8'h27;
      7'd41: val = 8'h0A;
      7'd43: val = 8'h1C;
      7'd44: val = 8'h1A;
      7'd45: val = 8'h18;
      7'd46: val = 8'h03;
      7'd47: val = 8'h16;
      7'd48: val = 8'h02;
      7'd49: val = 8'h0E;
      7'd50: val = 8'h0A;
      7'd51: val = 8'h2C;
      7'd52: val = 8'h2E;
      7'd55: val = 8'h2A;
      7'd57: val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/sc2a_decode.sv @@
module sc2a_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         byte_i,
  input  logic               take_i,
  output sc2a_pkg::dec_res_t res_o
);

  logic shift_q, shift_d;
  logic ctrl_q, ctrl_d;
  logic alt_q, alt_d;
  logic caps_q, caps_d;
  logic prefix_q, prefix_d;

  logic       pressed;
  logic [6:0] code;
  logic [7:0] us_val;
  logic [7:0] sh_val;
  logic [7:0] ct_val;
  logic       letter;
  logic       printable;
  logic [7:0] pick;

  assign pressed   = ~byte_i[7];
  assign code      = byte_i[6:0];
  assign us_val    = sc2a_pkg::us_rom(code);
  assign sh_val    = sc2a_pkg::shift_rom(code);
  assign ct_val    = sc2a_pkg::ctrl_rom(code);
  assign letter    = (us_val >= 8'h61) && (us_val <= 8'h7A);
  assign printable = ({1'b0, code} < 8'(sc2a_pkg::KeyCount));

  // Character choice by modifier priority
  always_comb begin
    if ((caps_q ^ shift_q) && letter) begin
      pick = sh_val;
    end else if (shift_q) begin
      pick = sh_val;
    end else if (ctrl_q) begin
      pick = ct_val;
    end else if (alt_q) begin
      pick = ct_val + sc2a_pkg::AltOffset;
    end else begin
      pick = us_val;
    end
  end

  // Modifier tracking and result
  always_comb begin
    shift_d       = shift_q;
    ctrl_d        = ctrl_q;
    alt_d         = alt_q;
    caps_d        = caps_q;
    prefix_d      = prefix_q;
    res_o.emit      = 1'b0;
    res_o.char_code = pick;
    if (byte_i == sc2a_pkg::PrefixByte) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      if (code == sc2a_pkg::KeyCtrl) begin
        ctrl_d = pressed;
      end else if (code == sc2a_pkg::KeyAlt) begin
        alt_d = pressed;
      end else if (code == sc2a_pkg::KeyLeft && pressed) begin
        res_o.emit      = 1'b1;
        res_o.char_code = sc2a_pkg::CodeLeft;
      end else if (code == sc2a_pkg::KeyRight && pressed) begin
        res_o.emit      = 1'b1;
        res_o.char_code = sc2a_pkg::CodeRight;
      end
    end else if (code == sc2a_pkg::KeyLshift || code == sc2a_pkg::KeyRshift) begin
      shift_d = pressed;
    end else if (code == sc2a_pkg::KeyCtrl) begin
      ctrl_d = pressed;
    end else if (code == sc2a_pkg::KeyAlt) begin
      alt_d = pressed;
    end else if (code == sc2a_pkg::KeyCaps) begin
      caps_d = caps_q ^ pressed;
    end else begin
      res_o.emit = printable && pressed;
    end
  end

  // Flags move only when the item leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
      alt_q    <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else if (take_i) begin
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
      alt_q    <= alt_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

  a_prefix_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && byte_i == sc2a_pkg::PrefixByte |=> prefix_q)
    else $error("prefix flag not set after prefix byte");

  a_caps_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && code != sc2a_pkg::KeyCaps |=> $stable(caps_q))
    else $error("caps changed on a non-caps item");

  a_ctrl_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && code == sc2a_pkg::KeyCtrl |=> ctrl_q == !$past(byte_i[7]))
    else $error("ctrl flag does not follow ctrl key");

endmodule

@@ hdl/scancode_to_ascii_decoder.sv @@
// An accepted scan byte enters the input register, then goes through decode
// and lookup into the result register.
// Throughput: one scan byte per cycle; the input stalls only while an item
// that emits a character waits behind a stalled, full result register.
// Reset (rst_ni low, asynchronous): both stages empty, all modifier flags clear.
module scancode_to_ascii_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_code_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  logic [7:0] out_char_q;

  sc2a_pkg::dec_res_t dec;
  logic out_free;
  logic s1_take;
  logic in_take;

  // Result register can load when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_take    = s1_valid_q && (!dec.emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_take;
  assign in_take    = in_valid_i && !in_stall_o;

  sc2a_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (s1_byte_q),
    .take_i (s1_take),
    .res_o  (dec)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || s1_take) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= scan_byte_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_take && dec.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && dec.emit) begin
      out_char_q <= dec.char_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = out_char_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input stage");

  a_blocked_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && dec.emit && out_valid_q && out_stall_i
    |=> s1_valid_q && $stable(s1_byte_q))
    else $error("blocked item lost from input stage");

  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && dec.emit))
    else $error("result without an emitting item");

endmodule
